// ===== sv/rvm_pkg.sv =====
// Package: widths, constants and shared types of the rotation vector to matrix core.
package rvm_pkg;

  localparam int IN_FRAC_BITS  = 12;
  localparam int OUT_FRAC_BITS = 14;
  localparam int WORK_FRAC     = 30;
  localparam int SERIES_TERMS  = 8;
  localparam longint EPS_SQ_DEN = 100000000;

  localparam int IN_W  = 16;
  localparam int OUT_W = 16;
  localparam int D2_W  = 2 * IN_W;          // sum of three squares stays below 2^32
  localparam int SQ_W  = 2 * IN_W + 1;      // W^2 entries
  localparam int CW    = WORK_FRAC + 4;     // signed Q.30 coefficients with headroom
  localparam int TW    = WORK_FRAC + 1;     // series term magnitudes, up to 2^30

  // doubling steps needed to bring the largest d^2 below one
  localparam int NDBL = (2 * IN_W - 2 * IN_FRAC_BITS + 1) / 2;
  localparam int M_W  = $clog2(NDBL + 1);

  // d < 1e-4 exactly when d2 < ceil(2^(2F) / 1e8)
  localparam longint SMALL_LIM =
    ((64'sd1 <<< (2 * IN_FRAC_BITS)) + EPS_SQ_DEN - 1) / EPS_SQ_DEN;

  localparam logic signed [CW-1:0] ONE_Q  = CW'(1) <<< WORK_FRAC;
  localparam logic signed [CW-1:0] HALF_Q = CW'(1) <<< (WORK_FRAC - 1);

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
    logic signed [SQ_W-1:0] sxx;
    logic signed [SQ_W-1:0] syy;
    logic signed [SQ_W-1:0] szz;
    logic signed [SQ_W-1:0] sxy;
    logic signed [SQ_W-1:0] sxz;
    logic signed [SQ_W-1:0] syz;
    logic                   tiny;
    logic [M_W-1:0]         m;
    logic [WORK_FRAC-1:0]   u;
    logic [TW-1:0]          ta;
    logic [TW-1:0]          tb;
    logic [TW-1:0]          tc;
    logic signed [CW-1:0]   a;
    logic signed [CW-1:0]   b;
    logic signed [CW-1:0]   c;
  } rvm_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] m00;
    logic [OUT_W-1:0] m01;
    logic [OUT_W-1:0] m02;
    logic [OUT_W-1:0] m10;
    logic [OUT_W-1:0] m11;
    logic [OUT_W-1:0] m12;
    logic [OUT_W-1:0] m20;
    logic [OUT_W-1:0] m21;
    logic [OUT_W-1:0] m22;
  } rvm_res_t;

endpackage

// ===== sv/rvm_if.sv =====
// Interfaces: rotation vector request channel and matrix result channel.
interface rvm_in_if;
  import rvm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] rot_x;
  logic signed [IN_W-1:0] rot_y;
  logic signed [IN_W-1:0] rot_z;
  modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

interface rvm_out_if;
  import rvm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, output m00, output m01, output m02, output m10,
                  output m11, output m12, output m20, output m21, output m22,
                  input ready);
  modport sink   (input valid, input m00, input m01, input m02, input m10,
                  input m11, input m12, input m20, input m21, input m22,
                  output ready);
endinterface

// ===== sv/rotation_vector_to_matrix_core.sv =====
// Top level: rotation vector (Q3.12) to 3x3 rotation matrix (Q1.14), fully pipelined.
//
//   channel   direction  payload                         format
//   in_ch     sink       rot_x rot_y rot_z                signed Q3.12 radians
//   out_ch    source     m00 m01 m02 m10 .. m22           signed Q1.14, sat +/-1.0
//
// One request per cycle sustained while out_ch is not stalled; the pipeline runs through the
// front, series, doubling and output stages, the series part set by the seven series terms
// at two multiplier stages each.
// Reset (rst_n low, synchronous) clears only the valid bits; the datapath registers are not reset.
// A stall on out_ch freezes every stage at once, so nothing is lost or repeated;
// in_ch takes a request whenever the last stage is empty or being drained.
module rotation_vector_to_matrix_core (
  input  logic    clk,
  input  logic    rst_n,
  rvm_in_if.sink  in_ch,
  rvm_out_if.source out_ch
);
  import rvm_pkg::*;

  logic      en;
  logic      fr_v, se_v, db_v, out_v;
  rvm_item_t fr_item, se_item, db_item;
  rvm_res_t  res;

  // pipeline advance: last stage empty or its result taken this cycle
  assign en          = !out_v || out_ch.ready;
  assign in_ch.ready = en;

  rvm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .x         (in_ch.rot_x),
    .y         (in_ch.rot_y),
    .z         (in_ch.rot_z),
    .out_valid (fr_v),
    .out_item  (fr_item)
  );

  // sin(s)/s, (1-cos s)/s^2, cos s at s = d / 2^m
  rvm_series u_series (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_v),
    .in_item   (fr_item),
    .out_valid (se_v),
    .out_item  (se_item)
  );

  // undo the range reduction by m angle doublings
  rvm_double u_double (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (se_v),
    .in_item   (se_item),
    .out_valid (db_v),
    .out_item  (db_item)
  );

  // R = I + A*W + B*W^2, rounded and saturated
  rvm_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (db_v),
    .in_item   (db_item),
    .out_valid (out_v),
    .out_res   (res)
  );

  assign out_ch.valid = out_v;
  assign out_ch.m00   = res.m00;
  assign out_ch.m01   = res.m01;
  assign out_ch.m02   = res.m02;
  assign out_ch.m10   = res.m10;
  assign out_ch.m11   = res.m11;
  assign out_ch.m12   = res.m12;
  assign out_ch.m20   = res.m20;
  assign out_ch.m21   = res.m21;
  assign out_ch.m22   = res.m22;

endmodule

// ===== sv/rvm_front.sv =====
// Front end: squares and cross products, d^2, angle reduction count and series argument.
module rvm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [rvm_pkg::IN_W-1:0] x,
  input  logic signed [rvm_pkg::IN_W-1:0] y,
  input  logic signed [rvm_pkg::IN_W-1:0] z,
  output logic                      out_valid,
  output rvm_pkg::rvm_item_t        out_item
);
  import rvm_pkg::*;

  logic [1:0]             vld_r;
  rvm_item_t              s1_r, s1_nxt, s2_r, s2_nxt;
  logic signed [SQ_W+1:0] d2_full;
  logic [D2_W-1:0]        d2;
  logic [M_W-1:0]         m_sel;
  logic [63:0]            u_w;
  int                     sh;

  // stage 1: the six products
  always_comb begin
    s1_nxt     = '0;
    s1_nxt.x   = x;
    s1_nxt.y   = y;
    s1_nxt.z   = z;
    s1_nxt.sxx = SQ_W'(x) * SQ_W'(x);
    s1_nxt.syy = SQ_W'(y) * SQ_W'(y);
    s1_nxt.szz = SQ_W'(z) * SQ_W'(z);
    s1_nxt.sxy = SQ_W'(x) * SQ_W'(y);
    s1_nxt.sxz = SQ_W'(x) * SQ_W'(z);
    s1_nxt.syz = SQ_W'(y) * SQ_W'(z);
  end

  // stage 2: d^2, W^2 diagonal, reduction count, u = d^2 / 4^m in Q.30
  always_comb begin
    d2_full = s1_r.sxx + s1_r.syy + s1_r.szz;
    d2      = d2_full[D2_W-1:0];
    m_sel   = M_W'(NDBL);
    for (int k = NDBL; k >= 0; k--) begin
      if ((d2 >> (2 * IN_FRAC_BITS + 2 * k)) == '0) m_sel = M_W'(k);
    end
    u_w = '0;
    sh  = 0;
    for (int k = 0; k <= NDBL; k++) begin
      if (m_sel == M_W'(k)) begin
        sh = WORK_FRAC - 2 * IN_FRAC_BITS - 2 * k;
        if (sh >= 0) u_w = 64'(d2) << sh;
        else         u_w = 64'(d2) >> (-sh);
      end
    end
    s2_nxt       = s1_r;
    s2_nxt.sxx   = -(s1_r.syy + s1_r.szz);
    s2_nxt.syy   = -(s1_r.sxx + s1_r.szz);
    s2_nxt.szz   = -(s1_r.sxx + s1_r.syy);
    s2_nxt.tiny  = 64'(d2) < 64'(SMALL_LIM);
    s2_nxt.m     = m_sel;
    s2_nxt.u     = u_w[WORK_FRAC-1:0];
    s2_nxt.ta    = TW'(1) << WORK_FRAC;
    s2_nxt.tb    = TW'(1) << (WORK_FRAC - 1);
    s2_nxt.tc    = TW'(1) << WORK_FRAC;
    s2_nxt.a     = ONE_Q;
    s2_nxt.b     = HALF_Q;
    s2_nxt.c     = ONE_Q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = vld_r[1];
  assign out_item  = s2_r;

endmodule

// ===== sv/rvm_series.sv =====
// Taylor series for sin(s)/s, (1-cos s)/s^2 and cos s, two stages per term.
module rvm_series (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  rvm_pkg::rvm_item_t in_item,
  output logic               out_valid,
  output rvm_pkg::rvm_item_t out_item
);
  import rvm_pkg::*;

  localparam int NS = 2 * (SERIES_TERMS - 1);
  localparam int PW = 2 * WORK_FRAC + 1;
  localparam int RW = 32;
  localparam int QW = TW + RW;

  logic [NS-1:0] vld_r;
  rvm_item_t     st_r [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  for (genvar k = 1; k < SERIES_TERMS; k++) begin : g_term
    // exact floor division by a constant: multiply by ceil(2^(30+L)/den)
    localparam longint DEN_A = (2 * k) * (2 * k + 1);
    localparam longint DEN_B = (2 * k + 1) * (2 * k + 2);
    localparam longint DEN_C = (2 * k - 1) * (2 * k);
    localparam int L_A = $clog2(DEN_A);
    localparam int L_B = $clog2(DEN_B);
    localparam int L_C = $clog2(DEN_C);
    localparam longint RC_A = ((64'sd1 <<< (WORK_FRAC + L_A)) + DEN_A - 1) / DEN_A;
    localparam longint RC_B = ((64'sd1 <<< (WORK_FRAC + L_B)) + DEN_B - 1) / DEN_B;
    localparam longint RC_C = ((64'sd1 <<< (WORK_FRAC + L_C)) + DEN_C - 1) / DEN_C;

    rvm_item_t      prev, a_nxt, b_nxt;
    logic [QW-1:0]  qa, qb, qc;

    if (k == 1) begin : g_first
      assign prev = in_item;
    end else begin : g_next
      assign prev = st_r[2*k-3];
    end

    // term * u
    always_comb begin
      a_nxt    = prev;
      a_nxt.ta = TW'((PW'(prev.ta) * PW'(prev.u)) >> WORK_FRAC);
      a_nxt.tb = TW'((PW'(prev.tb) * PW'(prev.u)) >> WORK_FRAC);
      a_nxt.tc = TW'((PW'(prev.tc) * PW'(prev.u)) >> WORK_FRAC);
    end

    // divide by the step factor and accumulate with alternating sign
    always_comb begin
      qa = (QW'(st_r[2*k-2].ta) * QW'(RC_A)) >> (WORK_FRAC + L_A);
      qb = (QW'(st_r[2*k-2].tb) * QW'(RC_B)) >> (WORK_FRAC + L_B);
      qc = (QW'(st_r[2*k-2].tc) * QW'(RC_C)) >> (WORK_FRAC + L_C);
      b_nxt    = st_r[2*k-2];
      b_nxt.ta = TW'(qa);
      b_nxt.tb = TW'(qb);
      b_nxt.tc = TW'(qc);
      if ((k % 2) == 1) begin
        b_nxt.a = st_r[2*k-2].a - $signed(CW'(qa));
        b_nxt.b = st_r[2*k-2].b - $signed(CW'(qb));
        b_nxt.c = st_r[2*k-2].c - $signed(CW'(qc));
      end else begin
        b_nxt.a = st_r[2*k-2].a + $signed(CW'(qa));
        b_nxt.b = st_r[2*k-2].b + $signed(CW'(qb));
        b_nxt.c = st_r[2*k-2].c + $signed(CW'(qc));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[2*k-2] <= a_nxt;
        st_r[2*k-1] <= b_nxt;
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_item  = st_r[NS-1];

endmodule

// ===== sv/rvm_double.sv =====
// Angle doubling: one stage per possible step, applied while the step index is below m.
module rvm_double (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  rvm_pkg::rvm_item_t in_item,
  output logic               out_valid,
  output rvm_pkg::rvm_item_t out_item
);
  import rvm_pkg::*;

  logic [NDBL-1:0] vld_r;
  rvm_item_t       st_r [NDBL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NDBL-2:0], in_valid};
    end
  end

  for (genvar s = 0; s < NDBL; s++) begin : g_step
    rvm_item_t              prev, nxt;
    logic signed [2*CW-1:0] paa, pac, pcc;

    if (s == 0) begin : g_first
      assign prev = in_item;
    end else begin : g_next
      assign prev = st_r[s-1];
    end

    assign paa = prev.a * prev.a;
    assign pac = prev.a * prev.c;
    assign pcc = prev.c * prev.c;

    always_comb begin
      nxt = prev;
      if (prev.m > M_W'(s)) begin
        nxt.b = CW'(paa >>> (WORK_FRAC + 1));
        nxt.a = CW'(pac >>> WORK_FRAC);
        nxt.c = CW'(pcc >>> (WORK_FRAC - 1)) - ONE_Q;
      end
    end

    always_ff @(posedge clk) begin
      if (en) st_r[s] <= nxt;
    end
  end

  assign out_valid = vld_r[NDBL-1];
  assign out_item  = st_r[NDBL-1];

endmodule

// ===== sv/rvm_out.sv =====
// Output: coefficient products, Q.30 sum, round half up and saturate to +/-1.0.
module rvm_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  rvm_pkg::rvm_item_t in_item,
  output logic               out_valid,
  output rvm_pkg::rvm_res_t  out_res
);
  import rvm_pkg::*;

  localparam int LP_W = CW + IN_W;
  localparam int QP_W = CW + SQ_W;
  localparam int EW   = QP_W + 2;
  localparam int RS   = WORK_FRAC - OUT_FRAC_BITS;

  typedef struct packed {
    logic signed [LP_W-1:0] px, py, pz;
    logic signed [QP_W-1:0] qxx, qyy, qzz, qxy, qxz, qyz;
  } rvm_prod_t;

  logic [1:0]           vld_r;
  rvm_prod_t            p_r, p_nxt;
  rvm_res_t             res_r, res_nxt;
  logic signed [CW-1:0] ca, cb;

  function automatic logic [OUT_W-1:0] mk_entry(input logic signed [EW-1:0] lin,
                                                input logic signed [EW-1:0] quad,
                                                input logic diag);
    logic signed [EW-1:0] e;
    logic signed [EW-1:0] r;
    logic signed [EW-1:0] lim;
    lim = EW'(1) <<< OUT_FRAC_BITS;
    e   = (lin >>> IN_FRAC_BITS) + (quad >>> (2 * IN_FRAC_BITS));
    if (diag) e = e + (EW'(1) <<< WORK_FRAC);
    if (RS > 0) r = (e + (EW'(1) <<< (RS - 1))) >>> RS;
    else        r = e;
    if (r > lim)  r = lim;
    if (r < -lim) r = -lim;
    return r[OUT_W-1:0];
  endfunction

  // small angle: A = 1 and B = 1/2 reproduce I + W + W^2/2 exactly
  always_comb begin
    ca        = in_item.tiny ? ONE_Q  : in_item.a;
    cb        = in_item.tiny ? HALF_Q : in_item.b;
    p_nxt.px  = ca * in_item.x;
    p_nxt.py  = ca * in_item.y;
    p_nxt.pz  = ca * in_item.z;
    p_nxt.qxx = cb * in_item.sxx;
    p_nxt.qyy = cb * in_item.syy;
    p_nxt.qzz = cb * in_item.szz;
    p_nxt.qxy = cb * in_item.sxy;
    p_nxt.qxz = cb * in_item.sxz;
    p_nxt.qyz = cb * in_item.syz;
  end

  always_comb begin
    res_nxt.m00 = mk_entry('0, EW'(p_r.qxx), 1'b1);
    res_nxt.m11 = mk_entry('0, EW'(p_r.qyy), 1'b1);
    res_nxt.m22 = mk_entry('0, EW'(p_r.qzz), 1'b1);
    res_nxt.m01 = mk_entry(-EW'(p_r.pz), EW'(p_r.qxy), 1'b0);
    res_nxt.m10 = mk_entry( EW'(p_r.pz), EW'(p_r.qxy), 1'b0);
    res_nxt.m02 = mk_entry( EW'(p_r.py), EW'(p_r.qxz), 1'b0);
    res_nxt.m20 = mk_entry(-EW'(p_r.py), EW'(p_r.qxz), 1'b0);
    res_nxt.m12 = mk_entry(-EW'(p_r.px), EW'(p_r.qyz), 1'b0);
    res_nxt.m21 = mk_entry( EW'(p_r.px), EW'(p_r.qyz), 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_valid = vld_r[1];
  assign out_res   = res_r;

endmodule
